// ===== src/rational_arithmetic_unit_core_macros.svh =====
// Assertion macros for the rational arithmetic unit checker.
// No dependencies; included by the checker file only.
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH

// same-cycle implication
`define RAU_AST_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RAU_AST_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rau_pkg.sv =====
// Package for the rational arithmetic unit: beat types, codes, widths.
// No dependencies.
`default_nettype none
package rau_pkg;

  localparam int WORD_BITS = 32;
  localparam int MAG_W     = 64;
  localparam logic [MAG_W-1:0] LIM = {{(MAG_W-1){1'b0}}, 1'b1} << (WORD_BITS - 1);

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] a_num;
    logic [30:0]        a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         status;
    logic [1:0]         order;
  } rau_out_t;

endpackage
`default_nettype wire

// ===== src/rau_gcd.sv =====
// Binary GCD unit: strips common twos, then subtract-and-shift one step a cycle.
// Depends on rau_pkg. Inputs must both be nonzero.
`default_nettype none
module rau_gcd (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [rau_pkg::MAG_W-1:0] x_i,
  input  wire logic [rau_pkg::MAG_W-1:0] y_i,
  output logic                         done_o,
  output logic [rau_pkg::MAG_W-1:0]    xs_o,
  output logic [rau_pkg::MAG_W-1:0]    ys_o,
  output logic [rau_pkg::MAG_W-1:0]    g_o
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    G_IDLE = 4'b0001,
    G_TWO  = 4'b0010,
    G_X    = 4'b0100,
    G_Y    = 4'b1000
  } gstate_e;

  gstate_e state_q, state_d;
  logic [MAG_W-1:0] x_q, x_d, y_q, y_d, xs_q, xs_d, ys_q, ys_d;

  always_comb begin
    state_d = state_q;
    x_d  = x_q;
    y_d  = y_q;
    xs_d = xs_q;
    ys_d = ys_q;
    case (state_q)
      G_IDLE: begin
        if (start_i) begin
          x_d = x_i;
          y_d = y_i;
          state_d = G_TWO;
        end
      end
      G_TWO: begin
        if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
        end else begin
          // both operands with the common power of two removed
          xs_d = x_q;
          ys_d = y_q;
          state_d = G_X;
        end
      end
      G_X: begin
        if (!x_q[0]) x_d = x_q >> 1;
        else state_d = G_Y;
      end
      G_Y: begin
        if (y_q == '0) begin
          state_d = G_IDLE;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (x_q > y_q) begin
          x_d = y_q;
          y_d = x_q - y_q;
        end else begin
          y_d = y_q - x_q;
        end
      end
      default: state_d = G_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    y_q  <= y_d;
    xs_q <= xs_d;
    ys_q <= ys_d;
  end

  assign done_o = (state_q == G_Y) && (y_q == '0);
  assign xs_o   = xs_q;
  assign ys_o   = ys_q;
  assign g_o    = x_q;

endmodule
`default_nettype wire

// ===== src/rau_div.sv =====
// Restoring divider, one quotient bit per cycle over the full word.
// Depends on rau_pkg.
`default_nettype none
module rau_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [rau_pkg::MAG_W-1:0] dividend_i,
  input  wire logic [rau_pkg::MAG_W-1:0] divisor_i,
  output logic                           done_o,
  output logic [rau_pkg::MAG_W-1:0]      quot_o
);
  import rau_pkg::*;

  localparam int CW = $clog2(MAG_W);

  logic          run_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [MAG_W-1:0] rem_q, quo_q, dvs_q;
  logic [MAG_W:0]   trial, diff;

  assign trial = {rem_q, quo_q[MAG_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(MAG_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      if (!diff[MAG_W]) begin
        rem_q <= diff[MAG_W-1:0];
        quo_q <= {quo_q[MAG_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[MAG_W-1:0];
        quo_q <= {quo_q[MAG_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

// ===== src/rational_arithmetic_unit_core.sv =====
// Rational arithmetic unit. An item that errors or whose result is zero
// finishes at the magnitude step; otherwise it also goes through the GCD
// steps (one shift or subtract a cycle in the binary GCD unit) and the two
// serial restoring divisions by the GCD, one after the other. The four cross
// products go one per cycle through a single 32x32 multiplier. busy is high
// from the accepting edge until the result beat; done_o marks that beat for
// one cycle and the receiver cannot stall it.
// Depends on rau_pkg, rau_gcd, rau_div.
`default_nettype none
module rational_arithmetic_unit_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire rau_pkg::rau_in_t cmd_i,
  output logic                  done_o,
  output rau_pkg::rau_out_t     res_o
);
  import rau_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_SUM  = 7'b0000100,
    S_MAG  = 7'b0001000,
    S_GCD  = 7'b0010000,
    S_DIVN = 7'b0100000,
    S_DIVD = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  rau_in_t in_q;
  logic [1:0] mcnt_q;
  logic signed [63:0] lhs_q, rhs_q, den_q, m3_q, num_q;
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod;
  logic err_q, neg_q;
  logic [1:0] order_q;
  logic [MAG_W-1:0] nm, dm, g_q, qn_q;
  logic gcd_start, gcd_done, div_start, div_done;
  logic [MAG_W-1:0] gcd_xs, gcd_ys, gcd_g, div_a, div_b, quot;
  logic done_q;
  rau_out_t res_q;
  logic ovf;
  logic signed [31:0] ad_s, bd_s;

  assign ad_s = $signed({1'b0, in_q.a_den});
  assign bd_s = $signed({1'b0, in_q.b_den});

  // shared multiplier: lhs, rhs, denominator, then num for multiply
  always_comb begin
    case (mcnt_q)
      2'd0:    begin op_a = in_q.a_num; op_b = bd_s; end
      2'd1:    begin op_a = in_q.b_num; op_b = ad_s; end
      2'd2:    begin op_a = ad_s; op_b = (in_q.kind == KIND_DIV) ? in_q.b_num : bd_s; end
      default: begin op_a = in_q.a_num; op_b = in_q.b_num; end
    endcase
  end
  assign prod = op_a * op_b;

  assign nm = num_q[63] ? MAG_W'(-num_q) : MAG_W'(num_q);
  assign dm = den_q[63] ? MAG_W'(-den_q) : MAG_W'(den_q);

  assign gcd_start = (state_q == S_MAG) && !err_q && (nm != '0);
  assign div_start = ((state_q == S_GCD) && gcd_done) || ((state_q == S_DIVN) && div_done);
  assign div_a     = (state_q == S_GCD) ? gcd_xs : gcd_ys;
  assign div_b     = (state_q == S_GCD) ? gcd_g : g_q;

  assign ovf = (quot > LIM - 1) || (neg_q ? (qn_q > LIM) : (qn_q > LIM - 1));

  rau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .x_i     (nm),
    .y_i     (dm),
    .done_o  (gcd_done),
    .xs_o    (gcd_xs),
    .ys_o    (gcd_ys),
    .g_o     (gcd_g)
  );

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start) state_d = S_MUL;
      S_MUL:  if (mcnt_q == 2'd3) state_d = S_SUM;
      S_SUM:  state_d = S_MAG;
      S_MAG:  state_d = gcd_start ? S_GCD : S_IDLE;
      S_GCD:  if (gcd_done) state_d = S_DIVN;
      S_DIVN: if (div_done) state_d = S_DIVD;
      S_DIVD: if (div_done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mcnt_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (state_q == S_MUL) mcnt_q <= mcnt_q + 1'b1;
      else                  mcnt_q <= '0;
      if ((state_q == S_MAG && !gcd_start) || (state_q == S_DIVD && div_done)) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) in_q <= cmd_i;
    if (state_q == S_MUL) begin
      case (mcnt_q)
        2'd0:    lhs_q <= prod;
        2'd1:    rhs_q <= prod;
        2'd2:    den_q <= prod;
        default: m3_q  <= prod;
      endcase
    end
    if (state_q == S_SUM) begin
      case (in_q.kind)
        KIND_ADD: num_q <= lhs_q + rhs_q;
        KIND_SUB: num_q <= lhs_q - rhs_q;
        KIND_MUL: num_q <= m3_q;
        default:  num_q <= lhs_q;
      endcase
      err_q   <= (in_q.a_den == '0) || (in_q.b_den == '0) || (den_q == '0);
      order_q <= (lhs_q < rhs_q) ? ORD_LT : ((lhs_q == rhs_q) ? ORD_EQ : ORD_GT);
    end
    if (state_q == S_MAG) begin
      neg_q <= num_q[63] != den_q[63];
      if (!gcd_start) begin
        res_q.res_num <= '0;
        res_q.res_den <= 31'd1;
        res_q.status  <= err_q ? ST_DIV0 : ST_OK;
        res_q.order   <= order_q;
      end
    end
    if (state_q == S_GCD && gcd_done) g_q <= gcd_g;
    if (state_q == S_DIVN && div_done) qn_q <= quot;
    if (state_q == S_DIVD && div_done) begin
      res_q.order <= order_q;
      if (ovf) begin
        res_q.res_num <= '0;
        res_q.res_den <= 31'd1;
        res_q.status  <= ST_OVF;
      end else begin
        res_q.res_num <= neg_q ? 32'(-qn_q) : qn_q[31:0];
        res_q.res_den <= quot[30:0];
        res_q.status  <= ST_OK;
      end
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

// ===== src/rau_checker.sv =====
// Port-level checker for rational_arithmetic_unit_core, with its bind.
// Depends on rau_pkg and rational_arithmetic_unit_core_macros.svh.
`default_nettype none
`include "rational_arithmetic_unit_core_macros.svh"
module rau_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done_o,
  input wire rau_pkg::rau_out_t res_o
);
  import rau_pkg::*;

  `RAU_AST_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accepted beat did not raise busy")
  `RAU_AST_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy, "result beat while still busy")
  `RAU_AST_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "result strobe held past one cycle")
  `RAU_AST_IMP(a_err_zero, clk_i, rst_ni, done_o && res_o.status != ST_OK,
               res_o.res_num == '0 && res_o.res_den == 31'd1, "error beat carries nonzero fraction")
  `RAU_AST_IMP(a_den_pos, clk_i, rst_ni, done_o, res_o.res_den != '0, "zero denominator in result")

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for rational_arithmetic_unit_core: fraction add, sub, mul, div.
// Predicts each result beat with an exact 64-bit model; depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import rau_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  rau_in_t  cmd_i = '0;
  logic     done_o;
  rau_out_t res_o;

  rau_out_t expected_q[$];
  int       n_errors = 0;
  int       n_results = 0;
  int       n_sent = 0;
  int       n_div0 = 0;
  int       n_ovf = 0;
  int       burst_left = 0;
  longint   cycles = 0;

  always #1 clk_i = ~clk_i;

  rational_arithmetic_unit_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cmd_i(cmd_i), .done_o(done_o), .res_o(res_o)
  );

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic rau_out_t fraction_result(rau_in_t c);
    rau_out_t    r;
    longint      an, ad, bn, bd, lhs, rhs, num, den;
    logic [63:0] nm, dm, g, lim;
    logic        neg;
    an  = longint'(c.a_num);
    ad  = longint'({1'b0, c.a_den});
    bn  = longint'(c.b_num);
    bd  = longint'({1'b0, c.b_den});
    lhs = an * bd;
    rhs = bn * ad;
    r.res_num = '0;
    r.res_den = 31'd1;
    r.status  = ST_OK;
    case (c.kind)
      KIND_ADD: begin num = lhs + rhs; den = ad * bd; end
      KIND_SUB: begin num = lhs - rhs; den = ad * bd; end
      KIND_MUL: begin num = an * bn;   den = ad * bd; end
      default:  begin num = lhs;       den = ad * bn; end
    endcase
    if (ad == 0 || bd == 0 || den == 0) begin
      r.status = ST_DIV0;
    end else begin
      neg = (num < 0) != (den < 0);
      nm  = (num < 0) ? -num : num;
      dm  = (den < 0) ? -den : den;
      g   = gcd64(nm, dm);
      nm  = nm / g;
      dm  = dm / g;
      if (nm == 0) neg = 1'b0;
      lim = 64'd1 << (WORD_BITS - 1);
      if (dm > lim - 1 || (neg ? nm > lim : nm > lim - 1)) begin
        r.status = ST_OVF;
      end else begin
        r.res_num = neg ? 32'(-nm) : 32'(nm);
        r.res_den = 31'(dm);
      end
    end
    r.order = (lhs < rhs) ? ORD_LT : ((lhs == rhs) ? ORD_EQ : ORD_GT);
    return r;
  endfunction

  // result checker: sampled at the rising edge
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_ni && done_o) begin
      n_results <= n_results + 1;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected beat %p", $time, res_o);
        n_errors++;
      end else begin
        if (res_o.res_num !== expected_q[0].res_num) begin
          $display("%0t res_num exp %0d got %0d", $time, expected_q[0].res_num, res_o.res_num);
          n_errors++;
        end
        if (res_o.res_den !== expected_q[0].res_den) begin
          $display("%0t res_den exp %0d got %0d", $time, expected_q[0].res_den, res_o.res_den);
          n_errors++;
        end
        if (res_o.status !== expected_q[0].status) begin
          $display("%0t status exp %0d got %0d", $time, expected_q[0].status, res_o.status);
          n_errors++;
        end
        if (res_o.order !== expected_q[0].order) begin
          $display("%0t order exp %0d got %0d", $time, expected_q[0].order, res_o.order);
          n_errors++;
        end
        void'(expected_q.pop_front());
      end
    end
  end

  // one beat: drive at the falling edge, wait for acceptance
  task automatic send_fraction_op(rau_in_t c);
    rau_out_t e;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30)) @(negedge clk_i);
    end
    burst_left--;
    cmd_i = c;
    start = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    e = fraction_result(c);
    if (e.status == ST_DIV0) n_div0++;
    if (e.status == ST_OVF) n_ovf++;
    expected_q.push_back(e);
    n_sent++;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic send_op(logic [1:0] k, logic [31:0] an, logic [30:0] ad,
                         logic [31:0] bn, logic [30:0] bd);
    rau_in_t c;
    c.kind = k; c.a_num = an; c.a_den = ad; c.b_num = bn; c.b_den = bd;
    send_fraction_op(c);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    logic [1:0] k;
    for (int i = 0; i < 4; i++) begin
      k = 2'(i);
      send_op(k, 32'd1, 31'd2, 32'd1, 31'd3);
      send_op(k, 32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 32'd1);
    end
    send_op(KIND_ADD, 32'd0, 31'd5, 32'd0, 31'd7);            // zero result
    send_op(KIND_DIV, 32'd3, 31'd4, 32'd0, 31'd9);            // divide by zero fraction
    send_op(KIND_ADD, 32'd3, 31'd0, 32'd1, 31'd2);            // zero denominator
    send_op(KIND_MUL, 32'd5, 31'd1, 32'd7, 31'd0);
    send_op(KIND_MUL, 32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1);  // overflow
    send_op(KIND_MUL, 32'h8000_0000, 31'd1, 32'hffff_ffff, 31'd1);
    send_op(KIND_SUB, 32'h8000_0000, 31'd1, 32'd0, 31'd1);    // most negative fits
    send_op(KIND_DIV, 32'h8000_0000, 31'd1, 32'hffff_ffff, 31'd1);
    send_op(KIND_SUB, 32'd2, 31'd4, 32'd1, 31'd2);            // equal operands
    send_op(KIND_DIV, 32'hffff_ffff, 31'h7fff_ffff, 32'd1, 31'd1);
    send_op(KIND_ADD, 32'h7fff_ffff, 31'h7fff_fffe, 32'h7fff_ffff, 31'h7fff_ffff);
    // sender holds off until everything is back
    wait_drained();
  endtask

  function automatic logic [31:0] rand_num();
    case ($urandom_range(0, 4))
      0: return 32'($signed($urandom_range(0, 40)) - 20);
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 100000)) * ($urandom_range(0, 1) ? 32'd1 : -32'd1);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(0, 5))
      0: return 31'($urandom_range(1, 12));
      1: return 31'h7fff_ffff;
      2: return 31'($urandom_range(1, 100000));
      3: return ($urandom_range(0, 30) == 0) ? 31'd0 : 31'($urandom_range(1, 64));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      send_op(2'($urandom_range(0, 3)), rand_num(), rand_den(), rand_num(), rand_den());
      if (i == n / 2) wait_drained();
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(1030);
    wait_drained();
    repeat (500) @(negedge clk_i);
    $display("Sent %0d fraction ops, checked %0d beats (%0d div-by-zero, %0d overflow).",
             n_sent, n_results, n_div0, n_ovf);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== rational_arithmetic_unit_core.f =====
+incdir+src
src/rau_pkg.sv
src/rau_gcd.sv
src/rau_div.sv
src/rational_arithmetic_unit_core.sv
src/rau_checker.sv
test/tb_top.sv
